// File: src/char_stream_calculator_defines.svh
// Assertion macros shared by the char_stream_calculator RTL.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef CHAR_STREAM_CALCULATOR_DEFINES_SVH
`define CHAR_STREAM_CALCULATOR_DEFINES_SVH

// Invariant checked at every rising clock edge outside reset.
`define CSC_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// Same-cycle implication.
`define CSC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/csc_pkg.sv
// Package for char_stream_calculator: widths, codes, payload structs, factorial table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package csc_pkg;

  localparam int OPERAND_BITS = 31;
  localparam int VALUE_W      = 63;
  localparam int STATUS_W     = 2;
  localparam int OP_W         = 3;
  localparam int DIGIT_W      = 4;
  localparam int JOB_DEPTH    = 2;
  localparam int FACT_LIMIT   = 20;
  localparam int FACT_IDX_W   = $clog2(FACT_LIMIT + 1);

  localparam logic [OPERAND_BITS-1:0] OPERAND_MAX = '1;

  // operator codes
  localparam logic [OP_W-1:0] OP_NONE = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
  localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV  = 3'd4;
  localparam logic [OP_W-1:0] OP_FACT = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DIV0  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADOP = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVF   = 2'd3;

  // character codes
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [7:0] char_code;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [STATUS_W-1:0]       status;
  } out_item_t;

  // one finished line, handed from parser to executor
  typedef struct packed {
    logic [OPERAND_BITS-1:0] a;
    logic [OPERAND_BITS-1:0] b;
    logic [OP_W-1:0]         op;
    logic                    ovf;
  } job_t;

  // n! for n up to FACT_LIMIT; 0! reads as 1
  function automatic logic [VALUE_W-1:0] fact_value(input logic [FACT_IDX_W-1:0] n);
    logic [VALUE_W-1:0] f;
    unique case (n)
      5'd0:    f = 63'd1;
      5'd1:    f = 63'd1;
      5'd2:    f = 63'd2;
      5'd3:    f = 63'd6;
      5'd4:    f = 63'd24;
      5'd5:    f = 63'd120;
      5'd6:    f = 63'd720;
      5'd7:    f = 63'd5040;
      5'd8:    f = 63'd40320;
      5'd9:    f = 63'd362880;
      5'd10:   f = 63'd3628800;
      5'd11:   f = 63'd39916800;
      5'd12:   f = 63'd479001600;
      5'd13:   f = 63'd6227020800;
      5'd14:   f = 63'd87178291200;
      5'd15:   f = 63'd1307674368000;
      5'd16:   f = 63'd20922789888000;
      5'd17:   f = 63'd355687428096000;
      5'd18:   f = 63'd6402373705728000;
      5'd19:   f = 63'd121645100408832000;
      5'd20:   f = 63'd2432902008176640000;
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

// File: src/csc_front.sv
// Character parser: builds operands and operator, emits one job per line end.
// Depends on csc_pkg and char_stream_calculator_defines.svh.
`timescale 1ns / 1ps
`include "char_stream_calculator_defines.svh"

module csc_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  csc_pkg::in_item_t char_in,
  output logic            job_push,
  output csc_pkg::job_t   job,
  input  logic            job_full
);
  import csc_pkg::*;

  localparam int EXT_W = OPERAND_BITS + DIGIT_W;

  logic [OPERAND_BITS-1:0] a;
  logic [OPERAND_BITS-1:0] b;
  logic [OP_W-1:0]         op;
  logic                    ovf;

  logic                    accept;
  logic                    is_digit;
  logic [DIGIT_W-1:0]      digit;
  logic [OP_W-1:0]         char_op;
  logic [OPERAND_BITS-1:0] acc_sel;
  logic [EXT_W-1:0]        acc_x10;
  logic                    sat;
  logic [OPERAND_BITS-1:0] acc_next;

  assign full     = job_full;
  assign accept   = push && !full;
  assign job_push = accept && char_in.line_end;
  assign job      = '{a: a, b: b, op: op, ovf: ovf};

  assign is_digit = (char_in.char_code >= CH_ZERO) && (char_in.char_code <= CH_NINE);
  assign digit    = DIGIT_W'(char_in.char_code - CH_ZERO);

  always_comb begin
    unique case (char_in.char_code)
      CH_PLUS:  char_op = OP_ADD;
      CH_MINUS: char_op = OP_SUB;
      CH_STAR:  char_op = OP_MUL;
      CH_SLASH: char_op = OP_DIV;
      CH_BANG:  char_op = OP_FACT;
      default:  char_op = OP_NONE;
    endcase
  end

  // acc * 10 + digit, saturating at the operand maximum
  assign acc_sel  = (op == OP_NONE) ? a : b;
  assign acc_x10  = (EXT_W'(acc_sel) << 3) + (EXT_W'(acc_sel) << 1) + EXT_W'(digit);
  assign sat      = acc_x10 > EXT_W'(OPERAND_MAX);
  assign acc_next = sat ? OPERAND_MAX : acc_x10[OPERAND_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      a   <= '0;
      b   <= '0;
      op  <= OP_NONE;
      ovf <= 1'b0;
    end else if (accept) begin
      if (char_in.line_end) begin
        a   <= '0;
        b   <= '0;
        op  <= OP_NONE;
        ovf <= 1'b0;
      end else if (char_in.char_code != CH_SPACE) begin
        if (is_digit) begin
          if (op == OP_NONE) begin
            a <= acc_next;
          end else begin
            b <= acc_next;
          end
          if (sat) begin
            ovf <= 1'b1;
          end
        end else if (char_op != OP_NONE) begin
          op <= char_op;
        end
      end
    end
  end

  // a saturated operand stays at the maximum until the line is cleared
  `CSC_ASSERT_IMPL(a_ovf_saturated, clk, rst, ovf, (a == OPERAND_MAX) || (b == OPERAND_MAX), "overflow flag without a saturated operand")

endmodule

// File: src/csc_job_fifo.sv
// Two-entry queue of parsed lines between parser and executor.
// Depends on csc_pkg.
`timescale 1ns / 1ps

module csc_job_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  csc_pkg::job_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output csc_pkg::job_t rd_data,
  output logic          empty
);
  import csc_pkg::*;

  localparam int PTR_W = $clog2(JOB_DEPTH);
  localparam int CNT_W = $clog2(JOB_DEPTH + 1);

  job_t             entries [JOB_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = count == CNT_W'(JOB_DEPTH);
  assign empty   = count == '0;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: src/csc_back.sv
// Executor: evaluates one job (add, sub, mul, serial divide, factorial table)
// and holds the result in an output register. Depends on csc_pkg and the defines header.
`timescale 1ns / 1ps
`include "char_stream_calculator_defines.svh"

module csc_back (
  input  logic               clk,
  input  logic               rst,
  input  csc_pkg::job_t      job,
  input  logic               job_valid,
  output logic               job_pop,
  output csc_pkg::out_item_t result,
  output logic               empty,
  input  logic               pop
);
  import csc_pkg::*;

  localparam int W      = OPERAND_BITS;
  localparam int PROD_W = 2 * OPERAND_BITS;
  localparam int CNT_W  = $clog2(OPERAND_BITS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]        state;
  logic [1:0]        state_next;
  out_item_t         res;
  out_item_t         res_next;
  out_item_t         out_reg;
  logic              out_valid;
  logic              out_free;

  logic [W-1:0]      div_rem;
  logic [W-1:0]      div_quo;
  logic [W-1:0]      div_den;
  logic [CNT_W-1:0]  div_cnt;
  logic [W:0]        div_shift;
  logic              div_ge;
  logic [W:0]        div_diff;

  logic [PROD_W-1:0] prod;
  logic              div_start;

  assign result   = out_reg;
  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;
  assign job_pop  = (state == S_IDLE) && job_valid;

  assign prod      = PROD_W'(job.a) * PROD_W'(job.b);
  assign div_shift = {div_rem, div_quo[W-1]};
  assign div_ge    = div_shift >= {1'b0, div_den};
  assign div_diff  = div_shift - {1'b0, div_den};

  // evaluation of a freshly popped job; divide only flags its start here
  always_comb begin
    res_next  = '{value: '0, status: ST_OK};
    div_start = 1'b0;
    priority if (job.op == OP_NONE || job.op > OP_FACT) begin
      res_next.status = ST_BADOP;
    end else if (job.ovf) begin
      res_next.status = ST_OVF;
    end else begin
      unique case (job.op)
        OP_ADD:  res_next.value = $signed(VALUE_W'(job.a) + VALUE_W'(job.b));
        OP_SUB:  res_next.value = $signed(VALUE_W'(job.a) - VALUE_W'(job.b));
        OP_MUL:  res_next.value = $signed(VALUE_W'(prod));
        OP_DIV: begin
          if (job.b == '0) begin
            res_next.status = ST_DIV0;
          end else begin
            div_start = 1'b1;
          end
        end
        OP_FACT: begin
          if (job.a > W'(FACT_LIMIT)) begin
            res_next.status = ST_OVF;
          end else begin
            res_next.value = $signed(fact_value(job.a[FACT_IDX_W-1:0]));
          end
        end
        default: res_next.status = ST_BADOP;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (job_valid) state_next = div_start ? S_DIV : S_DONE;
      S_DIV:   if (div_cnt == '0) state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && job_valid) begin
      res     <= res_next;
      div_rem <= '0;
      div_quo <= job.a;
      div_den <= job.b;
      div_cnt <= CNT_W'(W - 1);
    end else if (state == S_DIV) begin
      div_rem <= div_ge ? div_diff[W-1:0] : div_shift[W-1:0];
      div_quo <= {div_quo[W-2:0], div_ge};
      div_cnt <= div_cnt - 1'b1;
      if (div_cnt == '0) begin
        res.value  <= $signed(VALUE_W'({div_quo[W-2:0], div_ge}));
        res.status <= ST_OK;
      end
    end
    if (state == S_DONE && out_free) begin
      out_reg <= res;
    end
  end

  `CSC_ASSERT_IMPL(a_div_den_nonzero, clk, rst, state == S_DIV, div_den != '0, "divider running on a zero divisor")
  `CSC_ASSERT_NEXT(a_div_keeps_going, clk, rst, (state == S_DIV) && (div_cnt != '0), state == S_DIV, "divider left before its last quotient bit")
  `CSC_ASSERT_IMPL(a_err_value_zero, clk, rst, out_valid && (out_reg.status != ST_OK), out_reg.value == '0, "error result with nonzero value")

endmodule

// File: src/char_stream_calculator.sv
// Top level of the character-stream calculator: parser, job queue, executor.
// Depends on csc_pkg, csc_front, csc_job_fifo, csc_back.
`timescale 1ns / 1ps

// char_stream_calculator reads a text line one byte per transaction and
// returns one result transaction per line end. Digits before the first
// operator build the first operand, digits after it the second; + - * / !
// pick the operator (the last one wins), spaces and other bytes are skipped.
// Operands saturate at 2^31-1 and then report overflow (status 3). Results:
// sum, wrapped difference, full product, truncating quotient, or factorial of
// the first operand (0..20, 0! = 1). Status 1 is divide by zero, 2 a missing
// operator; value is zero whenever status is not 0.
// Timing: ordinary characters are taken one per cycle. A line end writes
// the parsed line into a two-line queue; the executor evaluates add,
// subtract, multiply and factorial directly, while divide runs the
// restoring divider that produces one quotient bit per cycle. The input only
// stalls (full high) while the line queue is full, and a finished result
// waits in an output register without blocking the next line's evaluation
// from starting once it has been handed over.

module char_stream_calculator (
  input  logic                clk,
  input  logic                rst,
  // input queue side
  input  logic                push,
  output logic                full,
  input  csc_pkg::in_item_t   char_in,
  // result queue side
  output logic                empty,
  input  logic                pop,
  output csc_pkg::out_item_t  result
);
  import csc_pkg::*;

  // parser -> queue
  logic  wr_job;
  job_t  wr_data;
  logic  q_full;
  // queue -> executor
  job_t  rd_data;
  logic  q_empty;
  logic  rd_job;

  // front: one byte per transaction, emits a job on line end
  csc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .char_in  (char_in),
    .job_push (wr_job),
    .job      (wr_data),
    .job_full (q_full)
  );

  // decouples parsing from long evaluations such as divide
  csc_job_fifo u_job_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_job),
    .wr_data (wr_data),
    .full    (q_full),
    .rd_en   (rd_job),
    .rd_data (rd_data),
    .empty   (q_empty)
  );

  // back: evaluates and presents results as a queue head
  csc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (rd_data),
    .job_valid (!q_empty),
    .job_pop   (rd_job),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule
